// ----- sv/fdss_pkg.sv -----
package fdss_pkg;

  localparam int unsigned DIGITS_DEF = 4;

  localparam int unsigned VALUE_W = 16;
  localparam int unsigned SEG_W   = 7;
  localparam int unsigned SEL_W   = 2;
  localparam int unsigned BCD_W   = 4;

  // floor(v / 10) == (v * RECIP_10) >> RECIP_SHIFT for every 16-bit v
  localparam int unsigned RECIP_W     = 17;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam logic [RECIP_W-1:0] RECIP_10 = 17'd52429;
  localparam int unsigned PROD_W = VALUE_W + RECIP_W;
  localparam int unsigned QUOT_W = VALUE_W - 3;

  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [BCD_W-1:0]   bcd_t;
  typedef logic [SEG_W-1:0]   seg_t;

  // Active-low glyphs, bit0 = a through bit6 = g; 6 and 9 drawn with tails.
  function automatic seg_t glyph_n(input bcd_t d);
    seg_t g;
    case (d)
      4'd0:    g = 7'h40;
      4'd1:    g = 7'h79;
      4'd2:    g = 7'h24;
      4'd3:    g = 7'h30;
      4'd4:    g = 7'h19;
      4'd5:    g = 7'h12;
      4'd6:    g = 7'h02;
      4'd7:    g = 7'h78;
      4'd8:    g = 7'h00;
      4'd9:    g = 7'h10;
      default: g = 7'h40;
    endcase
    return g;
  endfunction

endpackage

// ----- sv/four_digit_seven_segment_scan.sv -----
// Path: an accepted value passes through stage 0, the divide-by-ten stages and the scan
//   output register, and its digit beats leave one per cycle while the output is not stalled.
// Flow: the scan register sends one digit per beat and loads a new value once the last
//   digit of the previous one is taken; divide stages take a value each cycle unless stalled.
// Reset: synchronous, active low; clears all valid bits and the scan position.
module four_digit_seven_segment_scan #(
  parameter int unsigned DIGITS = fdss_pkg::DIGITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [fdss_pkg::VALUE_W-1:0] in_scaled_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [fdss_pkg::SEG_W-1:0]  out_segments_n,
  output logic [fdss_pkg::SEL_W-1:0]  out_digit_select,
  output logic                        out_last_digit
);
  import fdss_pkg::*;

  localparam int unsigned POS_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(DIGITS - 1);

  typedef bcd_t digits_t [0:DIGITS-1];

  // Pipeline: stage 0 captures the value, stage s+1 peels one decimal digit
  // off the value held in stage s (least significant digit first).
  logic   vld_r [0:DIGITS];
  value_t val_r [0:DIGITS];
  digits_t dig_r [0:DIGITS];
  logic   rdy   [0:DIGITS+1];

  // Scan output register.
  logic             out_valid_r, out_valid_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  digits_t          buf_r, buf_nxt;
  seg_t             seg_r, seg_nxt;
  logic             out_free, more, load_ok;

  // A stage takes a new beat when it is empty or its contents move on.
  genvar s;
  generate
    for (s = 0; s <= DIGITS; s++) begin : g_rdy
      assign rdy[s] = !vld_r[s] || rdy[s+1];
    end
  endgenerate
  assign rdy[DIGITS+1] = load_ok;
  assign in_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (rdy[0]) begin
      vld_r[0] <= in_valid;
    end
    if (rdy[0]) begin
      val_r[0] <= in_scaled_value;
      dig_r[0] <= '{default: '0};
    end
  end

  generate
    for (s = 0; s < DIGITS; s++) begin : g_stage
      logic [PROD_W-1:0] prod;
      logic [QUOT_W-1:0] quot;
      value_t            tens;
      value_t            rem;
      digits_t           dig_nxt;

      // Divide by ten through the reciprocal, then recover the remainder.
      assign prod = PROD_W'(val_r[s]) * PROD_W'(RECIP_10);
      assign quot = prod[RECIP_SHIFT +: QUOT_W];
      assign tens = (VALUE_W'(quot) << 3) + (VALUE_W'(quot) << 1);
      assign rem  = val_r[s] - tens;

      always_comb begin
        dig_nxt = dig_r[s];
        dig_nxt[DIGITS-1-s] = rem[BCD_W-1:0];
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[s+1] <= 1'b0;
        end else if (rdy[s+1]) begin
          vld_r[s+1] <= vld_r[s];
        end
        if (rdy[s+1]) begin
          val_r[s+1] <= VALUE_W'(quot);
          dig_r[s+1] <= dig_nxt;
        end
      end
    end
  endgenerate

  // Scan: hold the digits of one value and send them leftmost first. A new
  // value is loaded only once the final digit of the previous one is taken.
  assign out_free = !out_valid_r || !out_stall;
  assign more     = out_valid_r && (pos_r != POS_LAST);
  assign load_ok  = out_free && !more;

  always_comb begin
    out_valid_nxt = out_valid_r;
    pos_nxt       = pos_r;
    buf_nxt       = buf_r;
    seg_nxt       = seg_r;
    if (out_free) begin
      if (more) begin
        // advance to the next position of the held value
        pos_nxt = pos_r + 1'b1;
        seg_nxt = glyph_n(buf_r[pos_r + 1'b1]);
      end else begin
        // load the next value from the last stage, or drop to idle
        out_valid_nxt = vld_r[DIGITS];
        pos_nxt       = '0;
        buf_nxt       = dig_r[DIGITS];
        seg_nxt       = glyph_n(dig_r[DIGITS][0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pos_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
    end
    buf_r <= buf_nxt;
    seg_r <= seg_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_segments_n   = seg_r;
  assign out_digit_select = SEL_W'(pos_r);
  assign out_last_digit   = (pos_r == POS_LAST);

endmodule

// ----- verif/four_digit_seven_segment_scan_tb.sv -----
`timescale 1ns / 100ps

module four_digit_seven_segment_scan_tb;

  import fdss_pkg::*;

  localparam int unsigned NUM_DIGITS   = fdss_pkg::DIGITS_DEF;
  localparam realtime     CLK_PERIOD   = 12.0;
  localparam int unsigned RESET_CYCLES = 4;
  // Longest quiet stretch of a correct run is a sender gap or a receiver
  // hold; allow many times that.
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned RANDOM_VALUES = 350;

  // One digit beat as it should leave the block.
  typedef struct packed {
    seg_t                 seg_n;
    logic [SEL_W-1:0]     sel;
    logic                 last;
  } digit_beat_t;

  // Receiver back-pressure styles, cycled through at random.
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC,
    STALL_HOLD
  } stall_mode_e;

  // Works out the digit beats each accepted value must produce and
  // checks the beats that come out against them, oldest first.
  class glyph_scoreboard;
    digit_beat_t due_digits[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Active-low glyph, bit0 = a .. bit6 = g; 6 and 9 keep their tails.
    function seg_t glyph_of(int unsigned d);
      seg_t g;
      case (d)
        0:       g = 7'b1000000;
        1:       g = 7'b1111001;
        2:       g = 7'b0100100;
        3:       g = 7'b0110000;
        4:       g = 7'b0011001;
        5:       g = 7'b0010010;
        6:       g = 7'b0000010;
        7:       g = 7'b1111000;
        8:       g = 7'b0000000;
        default: g = 7'b0010000;
      endcase
      return g;
    endfunction

    function void note_value(value_t v);
      int unsigned rest;
      int unsigned dec[NUM_DIGITS];
      digit_beat_t beat;
      rest = 32'(v);
      // Peel decimal digits from the low end; anything above is dropped.
      for (int i = 0; i < NUM_DIGITS; i++) begin
        dec[NUM_DIGITS - 1 - i] = rest % 10;
        rest = rest / 10;
      end
      for (int i = 0; i < NUM_DIGITS; i++) begin
        beat.seg_n = glyph_of(dec[i]);
        beat.sel   = i[SEL_W-1:0];
        beat.last  = (i == NUM_DIGITS - 1);
        due_digits.push_back(beat);
      end
    endfunction

    function void check_digit(seg_t seg_n, logic [SEL_W-1:0] sel, logic last);
      digit_beat_t want;
      if (due_digits.size() == 0) begin
        mismatches++;
        $display("%0t: digit beat with none due: segments_n=%h digit_select=%0d last_digit=%b",
                 $time, seg_n, sel, last);
        return;
      end
      want = due_digits.pop_front();
      if (seg_n !== want.seg_n) begin
        mismatches++;
        $display("%0t: segments_n expected %h actual %h", $time, want.seg_n, seg_n);
      end
      if (sel !== want.sel) begin
        mismatches++;
        $display("%0t: digit_select expected %0d actual %0d", $time, want.sel, sel);
      end
      if (last !== want.last) begin
        mismatches++;
        $display("%0t: last_digit expected %b actual %b", $time, want.last, last);
      end
    endfunction

    function int unsigned pending();
      return due_digits.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  value_t               in_scaled_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  seg_t                 out_segments_n;
  logic [SEL_W-1:0]     out_digit_select;
  logic                 out_last_digit;

  glyph_scoreboard scan_board = new();
  int unsigned     quiet_cycles = 0;

  // Receiver pattern state.
  stall_mode_e     stall_mode = STALL_NONE;
  int unsigned     stall_span = 0;
  int unsigned     stall_period = 2;
  int unsigned     stall_phase = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  four_digit_seven_segment_scan #(
    .DIGITS(NUM_DIGITS)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_scaled_value  (in_scaled_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_segments_n   (out_segments_n),
    .out_digit_select (out_digit_select),
    .out_last_digit   (out_last_digit)
  );

  // Monitor both channels on the edge: note every accepted value, check every
  // accepted digit beat, and track how long nothing has moved.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        scan_board.note_value(in_scaled_value);
      if (out_valid && !out_stall)
        scan_board.check_digit(out_segments_n, out_digit_select, out_last_digit);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver back-pressure: switch to a random style after a random span so stalls land
  // on every digit position, with stretches of no stalling in between.
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode   <= stall_mode_e'($urandom_range(0, 3));
      stall_span   <= $urandom_range(8, 60);
      stall_period <= $urandom_range(2, 5);
      stall_phase  <= 0;
      out_stall    <= 1'b0;
    end else begin
      stall_span <= stall_span - 1;
      stall_phase <= (stall_phase + 1 >= stall_period) ? 0 : stall_phase + 1;
      case (stall_mode)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_RANDOM:   out_stall <= ($urandom_range(0, 2) == 0);
        STALL_PERIODIC: out_stall <= (stall_phase == 0);
        default:        out_stall <= (stall_span > 4);
      endcase
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  initial begin
    while (quiet_cycles < QUIET_LIMIT)
      @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  // Present one value and hold it until the block takes the beat. Valid stays
  // high on return so a following call keeps the burst going.
  task automatic send_value(input value_t v);
    in_valid        <= 1'b1;
    in_scaled_value <= v;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
  endtask

  // Drop valid and idle the sender for a number of cycles.
  task automatic pause_sender(input int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  initial begin
    value_t      values[$];
    int unsigned burst_left;
    int unsigned pick;
    int unsigned d3, d2, d1, d0;
    value_t      v;

    // Directed part: field extremes, every glyph, values of five digits
    // whose top digit must be dropped, and leading zeros.
    values = '{16'd0, 16'd65535, 16'd9999, 16'd10000, 16'd12345, 16'd1234,
               16'd5678, 16'd9090, 16'd6969, 16'd1, 16'd99, 16'd100,
               16'd8888, 16'd60000, 16'd32768, 16'd50005, 16'd7070, 16'd4321,
               16'd19999, 16'd65530};

    // Random part: plain 16-bit values, values under ten thousand, small
    // values full of leading zeros, and digit patterns heavy in 0 and 9 with
    // an optional top digit to be dropped.
    for (int n = 0; n < RANDOM_VALUES; n++) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        v = value_t'($urandom_range(0, 65535));
      end else if (pick < 6) begin
        v = value_t'($urandom_range(0, 9999));
      end else if (pick < 7) begin
        v = value_t'($urandom_range(0, 99));
      end else begin
        d3 = ($urandom_range(0, 2) == 0) ? 9 * $urandom_range(0, 1) : $urandom_range(0, 9);
        d2 = ($urandom_range(0, 2) == 0) ? 9 * $urandom_range(0, 1) : $urandom_range(0, 9);
        d1 = ($urandom_range(0, 2) == 0) ? 9 * $urandom_range(0, 1) : $urandom_range(0, 9);
        d0 = ($urandom_range(0, 2) == 0) ? 9 * $urandom_range(0, 1) : $urandom_range(0, 9);
        v = value_t'(10000 * $urandom_range(0, 5) + 1000 * d3 + 100 * d2 + 10 * d1 + d0);
      end
      values.push_back(v);
    end

    // Hold reset low, then release it once.
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Drive in bursts; gaps of random length land on every scan phase, and
    // the odd long burst gives a stretch with no sender idling.
    burst_left = 0;
    foreach (values[i]) begin
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 50)
                                                  : $urandom_range(1, 8);
        pick = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
        if (pick != 0)
          pause_sender(pick);
      end
      send_value(values[i]);
      burst_left--;
    end
    in_valid <= 1'b0;

    // Drain: wait for every due digit, then keep clocking to catch strays.
    while (scan_board.pending() != 0)
      @(posedge clk);
    repeat (2 * NUM_DIGITS + 8) @(posedge clk);

    if (scan_board.mismatches == 0 && scan_board.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- four_digit_seven_segment_scan.f -----
sv/fdss_pkg.sv
sv/four_digit_seven_segment_scan.sv
verif/four_digit_seven_segment_scan_tb.sv
